[sv/disk_sweep_scheduler_unit_defines.svh]
// ----------------------------------------------------------------------------
// disk_sweep_scheduler_unit_defines.svh
// Assertion macros for the checker file of the disk sweep scheduler.
// ----------------------------------------------------------------------------
`ifndef DISK_SWEEP_SCHEDULER_UNIT_DEFINES_SVH
`define DISK_SWEEP_SCHEDULER_UNIT_DEFINES_SVH

// Clocked property, ignored while reset is high.
`define DSS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked property that also holds during reset.
`define DSS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

[sv/dss_pkg.sv]
// ----------------------------------------------------------------------------
// dss_pkg
// Types and constants shared by the disk sweep scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dss_pkg;

  localparam int CYL_BITS    = 16;
  localparam int DIST_W      = 16;
  localparam int TOTAL_W     = 20;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int TDATA_IN_W  = 16;
  localparam int TDATA_OUT_W = 56;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [1:0] POL_SCAN  = 2'd1;
  localparam logic [1:0] POL_CSCAN = 2'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HEAD_START = 2'd0,
    REG_DISK_CYL   = 2'd1,
    REG_SWEEP_UP   = 2'd2,
    REG_POLICY     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PC_FCFS,
    PC_SCAN,
    PC_CSCAN
  } pclass_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SPLIT,
    ST_RUN1,
    ST_EDGE1,
    ST_EDGE2,
    ST_RUN2
  } state_t;

  typedef enum logic [1:0] {
    LD_NONE,
    LD_RUN1,
    LD_RUN2,
    LD_FCFS
  } load_t;

  typedef enum logic [1:0] {
    SRC_SORTED,
    SRC_ARRIVAL,
    SRC_TOP,
    SRC_ZERO
  } src_t;

  typedef struct packed {
    logic  in_ready;
    load_t load;
    logic  split_step;
    logic  emit;
    src_t  src;
    logic  edge_mv;
    logic  last_res;
  } cmd_t;

  typedef struct packed {
    pclass_t pclass;
    logic    sweep_up;
    logic    batch_done;
    logic    split_done;
    logic    rem_zero;
    logic    rem_one;
    logic    run2_empty;
    logic    slot_free;
  } status_t;

endpackage

`default_nettype wire

[sv/dss_ctrl.sv]
// ----------------------------------------------------------------------------
// dss_ctrl
// Sequencer: load, split search, first run, edge moves, second run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dss_pkg::status_t sts,
  output dss_pkg::cmd_t        cmd
);
  import dss_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (sts.batch_done) state_next = ST_SPLIT;
      end
      ST_SPLIT: begin
        if (sts.pclass == PC_FCFS || sts.split_done) state_next = ST_RUN1;
      end
      ST_RUN1: begin
        if (sts.rem_zero) begin
          state_next = ST_EDGE1;
        end else if (sts.slot_free && sts.rem_one) begin
          state_next = (sts.pclass == PC_FCFS) ? ST_LOAD : ST_EDGE1;
        end
      end
      ST_EDGE1: begin
        if (sts.slot_free) begin
          if (sts.pclass == PC_CSCAN) state_next = ST_EDGE2;
          else state_next = sts.run2_empty ? ST_LOAD : ST_RUN2;
        end
      end
      ST_EDGE2: begin
        if (sts.slot_free) state_next = sts.run2_empty ? ST_LOAD : ST_RUN2;
      end
      ST_RUN2: begin
        if (sts.slot_free && sts.rem_one) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.load = LD_NONE;
    cmd.src  = SRC_SORTED;
    unique case (state)
      ST_LOAD: begin
        // no beats taken while reset is high
        cmd.in_ready = !rst;
      end
      ST_SPLIT: begin
        if (sts.pclass == PC_FCFS) cmd.load = LD_FCFS;
        else if (sts.split_done) cmd.load = LD_RUN1;
        else cmd.split_step = 1'b1;
      end
      ST_RUN1: begin
        if (!sts.rem_zero && sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.src      = (sts.pclass == PC_FCFS) ? SRC_ARRIVAL : SRC_SORTED;
          cmd.last_res = (sts.pclass == PC_FCFS) && sts.rem_one;
        end
      end
      ST_EDGE1: begin
        if (sts.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.edge_mv = 1'b1;
          cmd.src     = sts.sweep_up ? SRC_TOP : SRC_ZERO;
          if (sts.pclass != PC_CSCAN) begin
            cmd.load     = LD_RUN2;
            cmd.last_res = sts.run2_empty;
          end
        end
      end
      ST_EDGE2: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.edge_mv  = 1'b1;
          cmd.src      = sts.sweep_up ? SRC_ZERO : SRC_TOP;
          cmd.load     = LD_RUN2;
          cmd.last_res = sts.run2_empty;
        end
      end
      ST_RUN2: begin
        if (sts.slot_free) begin
          cmd.emit     = 1'b1;
          cmd.last_res = sts.rem_one;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/dss_datapath.sv]
// ----------------------------------------------------------------------------
// dss_datapath
// Config registers, request stores, sorted insert cells, run counters,
// head/total arithmetic and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dss_datapath #(
  parameter int MAX_REQUESTS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [dss_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [dss_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               s_tvalid,
  input  wire logic [dss_pkg::CYL_BITS-1:0]       cylinder,
  input  wire logic                               s_tlast,
  input  wire logic                               m_tready,
  input  wire dss_pkg::cmd_t                      cmd,
  output dss_pkg::status_t                        sts,
  output logic                                    m_tvalid,
  output logic [dss_pkg::CYL_BITS-1:0]            target,
  output logic                                    edge_move,
  output logic [dss_pkg::DIST_W-1:0]              distance,
  output logic [dss_pkg::TOTAL_W-1:0]             total_moved,
  output logic                                    final_res
);
  import dss_pkg::*;

  localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REQUESTS);

  // configuration
  logic [CYL_BITS-1:0] head_start;
  logic [16:0]         disk_cyl;
  logic                sweep_up;
  logic [1:0]          policy;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_start <= '0;
      disk_cyl   <= 17'h10000;
      sweep_up   <= 1'b1;
      policy     <= POL_SCAN;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_HEAD_START: head_start <= cfg_data[CYL_BITS-1:0];
        REG_DISK_CYL:   disk_cyl   <= cfg_data;
        REG_SWEEP_UP:   sweep_up   <= cfg_data[0];
        REG_POLICY:     policy     <= cfg_data[1:0];
        default:        policy     <= policy;
      endcase
    end
  end

  pclass_t pclass;
  always_comb begin
    if (policy == POL_SCAN) pclass = PC_SCAN;
    else if (policy == POL_CSCAN) pclass = PC_CSCAN;
    else pclass = PC_FCFS;
  end

  // top edge: cylinders - 1, saturated; zero cylinders wraps to all ones
  logic [16:0]         dc_m1;
  logic [CYL_BITS-1:0] top_edge;
  assign dc_m1    = disk_cyl - 17'd1;
  assign top_edge = dc_m1[16] ? '1 : dc_m1[CYL_BITS-1:0];

  // request intake
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_reg;
  logic             accept;
  logic             store_en;
  assign accept   = s_tvalid && cmd.in_ready;
  assign store_en = accept && (count < MAX_CNT);

  logic [CYL_BITS-1:0] arrival [MAX_REQUESTS];
  logic [CYL_BITS-1:0] cells   [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] gt;

  always_ff @(posedge clk) begin
    if (store_en) arrival[count[IDX_W-1:0]] <= cylinder;
  end

  // insert cells: entries above the new value shift up one place
  for (genvar gi = 0; gi < MAX_REQUESTS; gi++) begin : g_cell
    assign gt[gi] = (CNT_W'(gi) < count) && (cells[gi] > cylinder);
    if (gi == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (store_en && (count == '0 || gt[0])) cells[0] <= cylinder;
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (store_en && (count == CNT_W'(gi) || gt[gi])) begin
          cells[gi] <= gt[gi-1] ? cells[gi-1] : cylinder;
        end
      end
    end
  end

  // walk counters
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] s_reg;
  logic [CNT_W-1:0] rem;
  logic             run_up;
  logic [CNT_W-1:0] len2;
  logic [CNT_W-1:0] start2;

  assign len2 = sweep_up ? s_reg : (n_reg - s_reg);
  always_comb begin
    if (pclass == PC_SCAN) start2 = sweep_up ? (s_reg - CNT_W'(1)) : s_reg;
    else start2 = sweep_up ? '0 : (n_reg - CNT_W'(1));
  end

  logic item_emit;
  assign item_emit = cmd.emit && (cmd.src == SRC_SORTED || cmd.src == SRC_ARRIVAL);

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      n_reg  <= '0;
      idx    <= '0;
      s_reg  <= '0;
      rem    <= '0;
      run_up <= 1'b1;
    end else begin
      if (accept) begin
        if (s_tlast) begin
          count <= '0;
          n_reg <= store_en ? count + CNT_W'(1) : count;
          idx   <= '0;
        end else if (store_en) begin
          count <= count + CNT_W'(1);
        end
      end
      unique case (cmd.load)
        LD_FCFS: begin
          idx    <= '0;
          rem    <= n_reg;
          run_up <= 1'b1;
        end
        LD_RUN1: begin
          s_reg  <= idx;
          idx    <= sweep_up ? idx : (idx - CNT_W'(1));
          rem    <= sweep_up ? (n_reg - idx) : idx;
          run_up <= sweep_up;
        end
        LD_RUN2: begin
          idx    <= start2;
          rem    <= len2;
          run_up <= (pclass == PC_SCAN) ? !sweep_up : sweep_up;
        end
        LD_NONE: begin
          if (cmd.split_step) begin
            idx <= idx + CNT_W'(1);
          end else if (item_emit) begin
            idx <= run_up ? (idx + CNT_W'(1)) : (idx - CNT_W'(1));
            rem <= rem - CNT_W'(1);
          end
        end
        default: rem <= rem;
      endcase
    end
  end

  // head movement
  logic [CYL_BITS-1:0] head;
  logic [TOTAL_W-1:0]  total;
  logic [CYL_BITS-1:0] tgt;
  logic [DIST_W-1:0]   move_dist;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  total_sat;

  always_comb begin
    unique case (cmd.src)
      SRC_SORTED:  tgt = cells[idx[IDX_W-1:0]];
      SRC_ARRIVAL: tgt = arrival[idx[IDX_W-1:0]];
      SRC_TOP:     tgt = top_edge;
      SRC_ZERO:    tgt = '0;
      default:     tgt = '0;
    endcase
  end

  assign move_dist = (tgt > head) ? (tgt - head) : (head - tgt);
  assign sum       = {1'b0, total} + (TOTAL_W + 1)'(move_dist);
  assign total_sat = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      total <= '0;
    end else if (accept && s_tlast) begin
      head  <= head_start;
      total <= '0;
    end else if (cmd.emit) begin
      head  <= tgt;
      total <= total_sat;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      target      <= tgt;
      edge_move   <= cmd.edge_mv;
      distance    <= move_dist;
      total_moved <= total_sat;
      final_res   <= cmd.last_res;
    end
  end

  // status
  assign sts.pclass     = pclass;
  assign sts.sweep_up   = sweep_up;
  assign sts.batch_done = accept && s_tlast;
  assign sts.split_done = (idx == n_reg) || (cells[idx[IDX_W-1:0]] > head);
  assign sts.rem_zero   = (rem == '0);
  assign sts.rem_one    = (rem == CNT_W'(1));
  assign sts.run2_empty = (len2 == '0);
  assign sts.slot_free  = !m_tvalid || m_tready;

endmodule

`default_nettype wire

[sv/disk_sweep_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// disk_sweep_scheduler_unit
// Batch disk-arm scheduler: FCFS, SCAN and C-SCAN service order.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid/tready     tdata: cylinder; tlast: batch end
//  m_*      out  tvalid/tready     tdata: target, distance, total; tuser: edge;
//                                  tlast: last move of batch
//  cfg_*    in   cfg_valid/ready   cfg_addr: register index; cfg_data: value
//
// Requests load one per cycle into the sorted insert cells and the arrival
// store. After the batch end beat, the split search steps through each
// request at or below the head (FCFS skips it), then one move per cycle is
// issued while the output register is drained.
// The input is held off from the batch end beat until the last move is
// loaded into the output register. m_tready low stalls the sequencer.
// Reset (rst, synchronous) clears the count, head and total, restores the
// config defaults, and holds s_tready and cfg_ready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module disk_sweep_scheduler_unit #(
  parameter int MAX_REQUESTS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [dss_pkg::TDATA_IN_W-1:0]    s_tdata,   // [15:0] cylinder
  input  wire logic                              s_tlast,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic [dss_pkg::TDATA_OUT_W-1:0]        m_tdata,   // [15:0] target,
                                                            // [31:16] distance,
                                                            // [51:32] total_moved
  output logic                                   m_tuser,   // edge_move
  output logic                                   m_tlast,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dss_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  wire logic [dss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dss_pkg::*;

  cmd_t    cmd;
  status_t sts;

  logic [CYL_BITS-1:0] target;
  logic [DIST_W-1:0]   distance;
  logic [TOTAL_W-1:0]  total_moved;

  dss_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  dss_datapath #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .cylinder    (s_tdata[CYL_BITS-1:0]),
    .s_tlast     (s_tlast),
    .m_tready    (m_tready),
    .cmd         (cmd),
    .sts         (sts),
    .m_tvalid    (m_tvalid),
    .target      (target),
    .edge_move   (m_tuser),
    .distance    (distance),
    .total_moved (total_moved),
    .final_res   (m_tlast)
  );

  assign s_tready  = cmd.in_ready;
  assign cfg_ready = !rst;
  assign m_tdata   = {4'b0, total_moved, distance, target};

endmodule

`default_nettype wire

[sv/dss_checker.sv]
// ----------------------------------------------------------------------------
// dss_checker
// Port-level checks for the disk sweep scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "disk_sweep_scheduler_unit_defines.svh"

module dss_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            s_tlast,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [dss_pkg::TDATA_OUT_W-1:0] m_tdata,
  input wire logic                            m_tuser,
  input wire logic                            m_tlast
);
  import dss_pkg::*;

  `DSS_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> m_tvalid, "result beat dropped while stalled")
  `DSS_ASSERT(a_out_stable, clk, rst, (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "stalled result changed")
  `DSS_ASSERT(a_batch_closes, clk, rst, (s_tvalid && s_tready && s_tlast) |=> !s_tready, "input open after batch end")
  `DSS_ASSERT(a_total_covers, clk, rst, m_tvalid |-> (m_tdata[51:32] >= {4'b0, m_tdata[31:16]}), "total below move distance")

endmodule

bind disk_sweep_scheduler_unit dss_checker u_dss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

[tb/disk_sweep_scheduler_unit_tb.sv]
// ----------------------------------------------------------------------------
// disk_sweep_scheduler_unit_tb
// Self-checking bench for the batch disk-arm scheduler. Requests go in on the
// s_* stream, and every move beat on the m_* stream is compared field by field
// with the moves typed into its table row or worked out by the bench for the batch.
// A short directed table covers reset values, edges, store overflow and every
// policy and direction. Random batches then run under several register
// settings and three idling patterns, with one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module disk_sweep_scheduler_unit_tb;
  import dss_pkg::*;

  localparam int          MAX_REQ     = 8;
  localparam int          MAX_MOVES   = 12;
  localparam int          SETTLE_CYC  = 24;
  localparam int          LONG_HOLD   = 300;
  localparam int          DIR_ROWS    = 38;
  localparam logic [1:0]  POL_FCFS    = 2'd0;
  localparam logic [1:0]  POL_RSVD    = 2'd3;

  typedef struct packed {
    logic [15:0]        target;
    logic               edge_mv;
    logic [15:0]        distance;
    logic [TOTAL_W-1:0] total;
    logic               last;
  } move_t;

  typedef struct packed {
    logic        is_cfg;
    cfg_reg_t    reg_id;
    logic [16:0] val;
    logic [15:0] cyl;
    logic        last;
    logic [1:0]  n_typed;   // moves typed into the row; 0 means use the schedule
    move_t       m0;
    move_t       m1;
  } step_row_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [TDATA_IN_W-1:0]            s_tdata = '0;   // [15:0] cylinder
  logic                             s_tlast = 1'b0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0]           m_tdata;        // [15:0] target, [31:16] distance,
                                                    // [51:32] total_moved
  logic                             m_tuser;        // edge_move
  logic                             m_tlast;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [CFG_ADDR_W-1:0]            cfg_addr = '0;
  logic [CFG_DATA_W-1:0]            cfg_data = '0;

  disk_sweep_scheduler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // scheduler shadow: register copy, request store, arm position and total
  logic [15:0]        cfg_head = '0;
  logic [16:0]        cfg_cyls = 17'd65536;
  logic               cfg_up   = 1'b1;
  logic [1:0]         cfg_pol  = POL_SCAN;
  logic [15:0]        req_store [MAX_REQ];
  int                 req_count = 0;
  logic [15:0]        arm_pos   = '0;
  logic [TOTAL_W-1:0] arm_total = '0;
  move_t              plan [MAX_MOVES];
  int                 plan_n;
  move_t              moves_due [$];
  int                 mismatches = 0;

  int unsigned snd_idle_pct = 26;
  int unsigned rcv_idle_pct = 73;
  int          hold_asks = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  function automatic void plan_move(input logic [15:0] tgt, input logic at_edge);
    logic [15:0]      d;
    logic [TOTAL_W:0] sum;
    d = (tgt > arm_pos) ? tgt - arm_pos : arm_pos - tgt;
    sum = arm_total + d;
    arm_total = (sum > TOTAL_MAX) ? TOTAL_MAX : sum[TOTAL_W-1:0];
    arm_pos = tgt;
    plan[plan_n] = '{tgt, at_edge, d, arm_total, 1'b0};
    plan_n++;
  endfunction

  // Stores one request; on batch end fills plan[] with the service order.
  function automatic void take_request(input logic [15:0] cyl, input logic last);
    logic [15:0] srt [MAX_REQ];
    logic [15:0] v;
    logic [15:0] top;
    int          n;
    int          i;
    int          j;
    int          split;
    plan_n = 0;
    if (req_count < MAX_REQ) begin
      req_store[req_count] = cyl;
      req_count++;
    end
    if (!last) return;
    n = req_count;
    req_count = 0;
    arm_pos = cfg_head;
    arm_total = '0;
    if (cfg_pol != POL_SCAN && cfg_pol != POL_CSCAN) begin
      for (i = 0; i < n; i++) plan_move(req_store[i], 1'b0);
    end else begin
      for (i = 0; i < n; i++) srt[i] = req_store[i];
      for (i = 1; i < n; i++) begin
        v = srt[i];
        j = i;
        while (j > 0 && srt[j-1] > v) begin
          srt[j] = srt[j-1];
          j--;
        end
        srt[j] = v;
      end
      // upper group starts at the first request strictly above the head
      split = n;
      for (i = 0; i < n; i++)
        if (split == n && srt[i] > arm_pos) split = i;
      if (cfg_cyls == 17'd0 || cfg_cyls > 17'd65536) top = 16'hFFFF;
      else top = 16'(cfg_cyls - 17'd1);
      if (cfg_pol == POL_SCAN && cfg_up) begin
        for (i = split; i < n; i++) plan_move(srt[i], 1'b0);
        plan_move(top, 1'b1);
        for (i = split; i > 0; i--) plan_move(srt[i-1], 1'b0);
      end else if (cfg_pol == POL_SCAN) begin
        for (i = split; i > 0; i--) plan_move(srt[i-1], 1'b0);
        plan_move(16'd0, 1'b1);
        for (i = split; i < n; i++) plan_move(srt[i], 1'b0);
      end else if (cfg_up) begin
        for (i = split; i < n; i++) plan_move(srt[i], 1'b0);
        plan_move(top, 1'b1);
        plan_move(16'd0, 1'b1);
        for (i = 0; i < split; i++) plan_move(srt[i], 1'b0);
      end else begin
        for (i = split; i > 0; i--) plan_move(srt[i-1], 1'b0);
        plan_move(16'd0, 1'b1);
        plan_move(top, 1'b1);
        for (i = n; i > split; i--) plan_move(srt[i-1], 1'b0);
      end
    end
    if (plan_n > 0) plan[plan_n-1].last = 1'b1;
  endfunction

  function automatic logic [15:0] pick_cyl();
    case ($urandom_range(4))
      0: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1: return cfg_head;
      2: return cfg_head + 16'($urandom_range(64)) - 16'd32;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_req(input logic [15:0] cyl, input logic last, input logic [1:0] n_typed,
                          input move_t m0, input move_t m1);
    int i;
    if ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cyl;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    take_request(cyl, last);
    if (n_typed != 0) begin
      moves_due.push_back(m0);
      if (n_typed > 1) moves_due.push_back(m1);
    end else begin
      for (i = 0; i < plan_n; i++) moves_due.push_back(plan[i]);
    end
  endtask

  task automatic cfg_write(input cfg_reg_t reg_id, input logic [16:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= reg_id;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (reg_id)
      REG_HEAD_START: cfg_head = val[15:0];
      REG_DISK_CYL:   cfg_cyls = val;
      REG_SWEEP_UP:   cfg_up   = val[0];
      REG_POLICY:     cfg_pol  = val[1:0];
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // registers change only with no batch in flight
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (moves_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic step_row_t cfg_row(input cfg_reg_t r, input logic [16:0] v);
    step_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.reg_id = r;
    row.val    = v;
    return row;
  endfunction

  function automatic step_row_t req_row(input logic [15:0] c, input logic l);
    step_row_t row;
    row = '0;
    row.cyl  = c;
    row.last = l;
    return row;
  endfunction

  function automatic step_row_t chk_row(input logic [15:0] c, input logic [1:0] n,
                                        input move_t a, input move_t b);
    step_row_t row;
    row = req_row(c, 1'b1);
    row.n_typed = n;
    row.m0 = a;
    row.m1 = b;
    return row;
  endfunction

  // receiver: random tready, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin : beat_check
    move_t got;
    move_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[15:0], m_tuser, m_tdata[31:16], m_tdata[51:32], m_tlast};
      if (moves_due.size() == 0) begin
        $error("move beat with nothing expected: target %0d", got.target);
        mismatches++;
      end else begin
        want = moves_due.pop_front();
        if (got.target !== want.target) begin
          $error("target: expected %0d, got %0d", want.target, got.target);
          mismatches++;
        end
        if (got.edge_mv !== want.edge_mv) begin
          $error("edge_move: expected %0d, got %0d", want.edge_mv, got.edge_mv);
          mismatches++;
        end
        if (got.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", want.distance, got.distance);
          mismatches++;
        end
        if (got.total !== want.total) begin
          $error("total_moved: expected %0d, got %0d", want.total, got.total);
          mismatches++;
        end
        if (got.last !== want.last) begin
          $error("final_res: expected %0d, got %0d", want.last, got.last);
          mismatches++;
        end
      end
    end
  end

  step_row_t dir_tab [DIR_ROWS];

  initial begin
    int mode;
    int setting;
    int sent;
    int blen;
    int i;
    logic [16:0] head_val;
    logic [16:0] cyl_val;

    dir_tab = '{
      // reset values: SCAN up from cylinder 0 on the full disk
      chk_row(16'd100, 2'd2, '{16'd100, 1'b0, 16'd100, 20'd100, 1'b0},
                             '{16'd65535, 1'b1, 16'd65435, 20'd65535, 1'b1}),
      chk_row(16'd0, 2'd2, '{16'd65535, 1'b1, 16'd65535, 20'd65535, 1'b0},
                           '{16'd0, 1'b0, 16'd65535, 20'd131070, 1'b1}),
      chk_row(16'd65535, 2'd2, '{16'd65535, 1'b0, 16'd65535, 20'd65535, 1'b0},
                               '{16'd65535, 1'b1, 16'd0, 20'd65535, 1'b1}),
      cfg_row(REG_POLICY, 17'(POL_FCFS)),
      req_row(16'd65535, 1'b0),
      chk_row(16'd0, 2'd2, '{16'd65535, 1'b0, 16'd65535, 20'd65535, 1'b0},
                           '{16'd0, 1'b0, 16'd65535, 20'd131070, 1'b1}),
      // nine requests: the batch end beat lands on a full store and is dropped
      req_row(16'd10, 1'b0), req_row(16'd20000, 1'b0), req_row(16'd5, 1'b0),
      req_row(16'd65535, 1'b0), req_row(16'd0, 1'b0), req_row(16'd300, 1'b0),
      req_row(16'd300, 1'b0), req_row(16'd40000, 1'b0), req_row(16'd77, 1'b1),
      cfg_row(REG_POLICY, 17'(POL_RSVD)),
      chk_row(16'd7, 2'd1, '{16'd7, 1'b0, 16'd7, 20'd7, 1'b1}, '0),
      cfg_row(REG_POLICY, 17'(POL_SCAN)),
      cfg_row(REG_SWEEP_UP, 17'd0),
      cfg_row(REG_HEAD_START, 17'd1000),
      cfg_row(REG_DISK_CYL, 17'd2000),
      // request equal to the head, and one past the disk edge
      req_row(16'd1500, 1'b0), req_row(16'd1000, 1'b0), req_row(16'd200, 1'b0),
      req_row(16'd3000, 1'b1),
      cfg_row(REG_POLICY, 17'(POL_CSCAN)),
      cfg_row(REG_SWEEP_UP, 17'd1),
      req_row(16'd900, 1'b0), req_row(16'd1200, 1'b0), req_row(16'd1000, 1'b1),
      cfg_row(REG_SWEEP_UP, 17'd0),
      req_row(16'd500, 1'b0), req_row(16'd1500, 1'b1),
      cfg_row(REG_DISK_CYL, 17'd0),
      req_row(16'd1000, 1'b1),
      cfg_row(REG_DISK_CYL, 17'h1FFFF),
      cfg_row(REG_POLICY, 17'(POL_SCAN)),
      req_row(16'd2000, 1'b1)
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[r]) begin
      if (dir_tab[r].is_cfg) begin
        wait_idle();
        cfg_write(dir_tab[r].reg_id, dir_tab[r].val);
      end else begin
        send_req(dir_tab[r].cyl, dir_tab[r].last, dir_tab[r].n_typed,
                 dir_tab[r].m0, dir_tab[r].m1);
      end
    end

    for (mode = 0; mode < 3; mode++) begin
      snd_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 73 : 0;
      rcv_idle_pct = (mode == 0) ? 73 : (mode == 1) ? 26 : 0;
      for (setting = 0; setting < 3; setting++) begin
        wait_idle();
        case ($urandom_range(3))
          0: head_val = 17'd0;
          1: head_val = 17'h0FFFF;
          2: head_val = 17'h1FFFF;   // upper bit is dropped by the register
          default: head_val = 17'($urandom);
        endcase
        case ($urandom_range(5))
          0: cyl_val = 17'd0;
          1: cyl_val = 17'd65536;
          2: cyl_val = 17'($urandom_range(131071, 65537));
          3: cyl_val = 17'($urandom_range(16, 1));
          default: cyl_val = 17'($urandom_range(65536, 1));
        endcase
        cfg_write(REG_HEAD_START, head_val);
        cfg_write(REG_DISK_CYL, cyl_val);
        cfg_write(REG_SWEEP_UP, 17'($urandom));
        cfg_write(REG_POLICY, 17'($urandom));
        // stall the output while requests keep coming
        if (mode == 2 && setting == 0) hold_asks <= hold_asks + 1;
        sent = 0;
        while (sent < 6) begin
          blen = ($urandom_range(4) == 0) ? $urandom_range(11, 9) : $urandom_range(6, 1);
          for (i = 1; i <= blen; i++) begin
            send_req(pick_cyl(), i == blen, 2'd0, '0, '0);
            sent++;
          end
        end
      end
    end

    s_tvalid <= 1'b0;
    while (moves_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
